/* sv/keyed_sip_hash_2_4_macros.svh */
// ----------------------------------------------------------------------------
// keyed_sip_hash_2_4_macros.svh
// Assertion macros used by the hash engine RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_SIP_HASH_2_4_MACROS_SVH
`define KEYED_SIP_HASH_2_4_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check on clk, held off during reset.
`define KSH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("keyed_sip_hash_2_4 assertion failed");
// Expression must never be true.
`define KSH_ASSERT_NEVER(label, expr) `KSH_ASSERT(label, !(expr))
`else
`define KSH_ASSERT(label, prop)
`define KSH_ASSERT_NEVER(label, expr)
`endif

`endif

/* sv/ksh_pkg.sv */
// ----------------------------------------------------------------------------
// ksh_pkg
// Types and constants of the SipHash-2-4 engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ksh_pkg;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    localparam logic [63:0] INIT_C0   = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1   = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2   = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3   = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
    localparam int          LEN_SHIFT = 56;

    // Rounds per compressed block, and in total for a closing item
    localparam logic [2:0]  C_ROUNDS     = 3'd2;
    localparam logic [2:0]  TOTAL_ROUNDS = 3'd6;

endpackage

`default_nettype wire

/* sv/ksh_round.sv */
// ----------------------------------------------------------------------------
// ksh_round
// One SipRound over the four 64-bit lanes, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module ksh_round
    import ksh_pkg::*;
(
    input  wire lanes_t v_in,
    output lanes_t      v_out
);

    logic [63:0] a1, b1, c1, d1;
    logic [63:0] a2, b2, c2, d2;
    logic [63:0] a3, c3;

    always_comb
    begin
        // first half
        a1 = v_in.a + v_in.b;
        b1 = {v_in.b[50:0], v_in.b[63:51]} ^ a1;
        a2 = {a1[31:0], a1[63:32]};
        c1 = v_in.c + v_in.d;
        d1 = {v_in.d[47:0], v_in.d[63:48]} ^ c1;
        // second half
        a3 = a2 + d1;
        d2 = {d1[42:0], d1[63:43]} ^ a3;
        c2 = c1 + b1;
        b2 = {b1[46:0], b1[63:47]} ^ c2;
        c3 = {c2[31:0], c2[63:32]};

        v_out.a = a3;
        v_out.b = b2;
        v_out.c = c3;
        v_out.d = d2;
    end

endmodule

`default_nettype wire

/* sv/keyed_sip_hash_2_4.sv */
// Items pass one at a time through the single SipRound unit, one round per
// cycle except while a closing item waits for the output register to drain;
// in_ready stays low until the current item's last round is done.
// Reset (rst_n low, async): keys clear, no message open, no result pending.
// ----------------------------------------------------------------------------
// keyed_sip_hash_2_4
// SipHash-2-4 engine: 64-bit little-endian words in, one 64-bit hash per
// message out. Keys are written over an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_sip_hash_2_4_macros.svh"

module keyed_sip_hash_2_4
    import ksh_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    // configuration port: key_low at 0x0, key_high at 0x8
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input items
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [63:0] msg_word,
    input  wire  [2:0]  tail_bytes,
    input  wire         last,
    // result items
    output logic        out_valid,
    input  wire         out_ready,
    output logic [63:0] hash_value
);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // ------------------------------------------------------------------
    // Key registers. Only paddr[3] is decoded: it picks the key half.
    // ------------------------------------------------------------------
    logic [63:0] key_low_reg, key_high_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[3] ? key_high_reg : key_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
            begin
                key_high_reg <= pwdata;
            end
            else
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and lane state
    // ------------------------------------------------------------------
    logic        state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;       // rounds already done on this item
    logic        open_reg, open_next;     // message in progress
    logic        last_reg, last_next;     // item in flight closes the message
    logic [7:0]  len_reg, len_next;       // message length mod 256
    logic [63:0] blk_reg, blk_next;       // block folded into lane a
    lanes_t      lanes_reg, lanes_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;

    lanes_t      round_in, round_out, start_lanes;
    logic [7:0]  len_base, len_total;
    logic [63:0] in_block;
    logic        accept, final_step, fold_step, out_free;

    ksh_round u_round (
        .v_in  (round_in),
        .v_out (round_out)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;

    always_comb
    begin
        // lanes at the start of this item: fresh from the keys on a new message
        if (open_reg)
        begin
            start_lanes = lanes_reg;
            len_base    = len_reg;
        end
        else
        begin
            start_lanes.a = key_low_reg  ^ INIT_C0;
            start_lanes.b = key_high_reg ^ INIT_C1;
            start_lanes.c = key_low_reg  ^ INIT_C2;
            start_lanes.d = key_high_reg ^ INIT_C3;
            len_base      = '0;
        end

        // final block: tail bytes under the length byte; a full word as is
        len_total = len_base + {5'd0, tail_bytes};
        in_block  = msg_word;
        if (last)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (3'(i) >= tail_bytes)
                begin
                    in_block[8*i +: 8] = 8'd0;
                end
            end
            in_block[LEN_SHIFT +: 8] = len_total;
        end

        // round unit feed: first round runs in the accept cycle
        if (state_reg == ST_IDLE)
        begin
            round_in   = start_lanes;
            round_in.d = start_lanes.d ^ in_block;
        end
        else
        begin
            round_in = lanes_reg;
        end

        fold_step  = (state_reg == ST_RUN) && (cnt_reg == C_ROUNDS - 3'd1);
        final_step = (state_reg == ST_RUN) &&
                     (last_reg ? (cnt_reg == TOTAL_ROUNDS - 3'd1)
                               : (cnt_reg == C_ROUNDS - 3'd1));

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        open_next      = open_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        blk_next       = blk_reg;
        lanes_next     = lanes_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hash_next      = hash_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    cnt_next   = 3'd1;
                    open_next  = 1'b1;
                    last_next  = last;
                    len_next   = last ? 8'd0 : (len_base + 8'd8);
                    blk_next   = in_block;
                    lanes_next = round_out;
                end
            end
            ST_RUN:
            begin
                // a closing item waits for the output register to drain
                if (!(final_step && last_reg && !out_free))
                begin
                    lanes_next = round_out;
                    cnt_next   = cnt_reg + 3'd1;
                    if (fold_step)
                    begin
                        lanes_next.a = round_out.a ^ blk_reg;
                        if (last_reg)
                        begin
                            lanes_next.c = round_out.c ^ FINAL_XOR;
                        end
                    end
                    if (final_step)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = 3'd0;
                        if (last_reg)
                        begin
                            open_next      = 1'b0;
                            out_valid_next = 1'b1;
                            hash_next      = round_out.a ^ round_out.b ^
                                             round_out.c ^ round_out.d;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            open_reg      <= 1'b0;
            last_reg      <= 1'b0;
            len_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            open_reg      <= open_next;
            last_reg      <= last_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        lanes_reg <= lanes_next;
        hash_reg  <= hash_next;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `KSH_ASSERT(a_word_runs, accept |=> (state_reg == ST_RUN) && (cnt_reg == 3'd1))
    `KSH_ASSERT(a_run_count, (state_reg == ST_RUN) |-> (cnt_reg != 3'd0))
    `KSH_ASSERT(a_hash_closes, $rose(out_valid_reg) |-> !open_reg && $past(last_reg))
    `KSH_ASSERT_NEVER(a_count_range, cnt_reg >= TOTAL_ROUNDS)

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed_sip_hash_2_4 engine. A table of directed
// items (empty message, tail sizes, ignored bytes, key changes, two published
// known answers) runs first. Random messages under several keys follow, with
// random idle bursts on the input side and random stalls on the result side.
// Every hash_value is matched to a local SipHash-2-4 model or a known answer.
// ----------------------------------------------------------------------------
module testbench
    import ksh_pkg::*;
();

    // Register map: one 64-bit key half every 8 bytes
    localparam logic [3:0] KEY_LOW_ADDR  = 4'h0;
    localparam logic [3:0] KEY_HIGH_ADDR = 4'h8;

    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int N_DIR_ROWS      = 16;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KEYS
    } row_kind_t;

    // Item rows: value is a known hash when known is set.
    // Key rows: word goes to key_low, value to key_high.
    typedef struct packed {
        row_kind_t   kind;
        logic [63:0] word;
        logic [2:0]  tail;
        logic        last;
        logic        known;
        logic [63:0] value;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] msg_word;
    logic [2:0]  tail_bytes;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] hash_value;

    // Travels with the item: substitute a typed-in hash for the predicted one
    logic        item_known;
    logic [63:0] item_known_hash;

    // Local hash model state
    logic [63:0] key0_shadow = '0;
    logic [63:0] key1_shadow = '0;
    lanes_t      hash_lanes;
    logic [7:0]  msg_bytes = '0;
    bit          in_message = 1'b0;

    logic [63:0] hash_queue[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    int          stall_left = 0;
    stim_row_t   dir_rows [0:N_DIR_ROWS-1];

    keyed_sip_hash_2_4 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .msg_word   (msg_word),
        .tail_bytes (tail_bytes),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------
    function automatic logic [63:0] rotate_left(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic lanes_t sip_mix(input lanes_t v);
        v.a = v.a + v.b;
        v.b = rotate_left(v.b, 13) ^ v.a;
        v.a = rotate_left(v.a, 32);
        v.c = v.c + v.d;
        v.d = rotate_left(v.d, 16) ^ v.c;
        v.a = v.a + v.d;
        v.d = rotate_left(v.d, 21) ^ v.a;
        v.c = v.c + v.b;
        v.b = rotate_left(v.b, 17) ^ v.c;
        v.c = rotate_left(v.c, 32);
        return v;
    endfunction

    // Two rounds around one 8-byte block
    function automatic lanes_t compress_block(input lanes_t v, input logic [63:0] m);
        v.d = v.d ^ m;
        v = sip_mix(sip_mix(v));
        v.a = v.a ^ m;
        return v;
    endfunction

    // Advances the model by one item; returns 1 when the item closes a message
    function automatic bit absorb_item(input logic [63:0] word, input logic [2:0] tail,
                                       input logic is_last, output logic [63:0] digest);
        logic [63:0] tail_mask;
        logic [63:0] block;
        logic [7:0]  total;
        digest = '0;
        // keys are latched only at the start of a message
        if (!in_message)
        begin
            hash_lanes.a = key0_shadow ^ INIT_C0;
            hash_lanes.b = key1_shadow ^ INIT_C1;
            hash_lanes.c = key0_shadow ^ INIT_C2;
            hash_lanes.d = key1_shadow ^ INIT_C3;
            msg_bytes    = '0;
            in_message   = 1'b1;
        end
        if (!is_last)
        begin
            hash_lanes = compress_block(hash_lanes, word);
            msg_bytes  = msg_bytes + 8'd8;
            return 1'b0;
        end
        // bytes above the tail are dropped; length wraps at 256
        tail_mask  = (tail == 3'd0) ? 64'h0 : ((64'h1 << (8 * tail)) - 64'h1);
        total      = msg_bytes + {5'd0, tail};
        block      = ({56'h0, total} << LEN_SHIFT) | (word & tail_mask);
        hash_lanes = compress_block(hash_lanes, block);
        hash_lanes.c = hash_lanes.c ^ FINAL_XOR;
        hash_lanes = sip_mix(sip_mix(sip_mix(sip_mix(hash_lanes))));
        digest     = hash_lanes.a ^ hash_lanes.b ^ hash_lanes.c ^ hash_lanes.d;
        msg_bytes  = '0;
        in_message = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: tracks key writes and accepted items, checks results.
    // All values are sampled before the edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_blk
        logic [63:0] digest;
        logic [63:0] want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == KEY_LOW_ADDR)
                    key0_shadow = pwdata;
                else if (paddr == KEY_HIGH_ADDR)
                    key1_shadow = pwdata;
            end
            if (in_valid && in_ready)
            begin
                if (absorb_item(msg_word, tail_bytes, last, digest))
                    hash_queue.push_back(item_known ? item_known_hash : digest);
            end
            if (out_valid && out_ready)
            begin
                if (hash_queue.size() == 0)
                begin
                    $display("%0t: unexpected hash_value, expected none, got %h",
                             $time, hash_value);
                    mismatches++;
                end
                else
                begin
                    want = hash_queue.pop_front();
                    if (hash_value !== want)
                    begin
                        $display("%0t: hash_value expected %h, got %h",
                                 $time, want, hash_value);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side: ready with random stall bursts when enabled
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(1, 8) - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("keyed_sip_hash_2_4: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks. Each is entered and left right after a rising edge.
    // ------------------------------------------------------------------

    // Presents one item and holds it until accepted; valid stays high on exit
    task automatic send_item(input logic [63:0] word, input logic [2:0] tail,
                             input logic is_last, input logic known,
                             input logic [63:0] known_hash);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        msg_word        <= word;
        tail_bytes      <= tail;
        last            <= is_last;
        item_known      <= known;
        item_known_hash <= known_hash;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops the input and waits for every pending hash, then for the pipeline
    // to settle (full words leave no result to wait on)
    task automatic drain_engine();
        in_valid <= 1'b0;
        @(posedge clk);
        while (hash_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1);
        write_reg(KEY_LOW_ADDR, k0);
        write_reg(KEY_HIGH_ADDR, k1);
    endtask

    // Random message of n full words plus a closing item
    task automatic send_message(input int n_words);
        for (int i = 0; i < n_words; i++)
            send_item({$urandom, $urandom}, 3'($urandom_range(0, 7)), 1'b0, 1'b0, 64'h0);
        send_item({$urandom, $urandom}, 3'($urandom_range(0, 7)), 1'b1, 1'b0, 64'h0);
    endtask

    initial
    begin : stimulus_blk
        int        sent;
        int        n_words;
        bit        first_msg;
        stim_row_t row;

        // Directed part. Runs under the reset key first.
        dir_rows[0]  = '{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 3'd0, 1'b1, 1'b0, 64'h0};
        dir_rows[1]  = '{ROW_ITEM, 64'h0000_0000_0000_0000, 3'd7, 1'b0, 1'b0, 64'h0};
        dir_rows[2]  = '{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 3'd7, 1'b1, 1'b0, 64'h0};
        dir_rows[3]  = '{ROW_ITEM, 64'ha5a5_5a5a_c3c3_3c55, 3'd1, 1'b1, 1'b0, 64'h0};
        // published test key, bytes 00..0f
        dir_rows[4]  = '{ROW_KEYS, 64'h0706050403020100, 3'd0, 1'b0, 1'b0,
                         64'h0f0e0d0c0b0a0908};
        // empty message known answer
        dir_rows[5]  = '{ROW_ITEM, 64'h0, 3'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31};
        // 15-byte message 00..0e; stray top byte in the tail must be dropped
        dir_rows[6]  = '{ROW_ITEM, 64'h0706050403020100, 3'd3, 1'b0, 1'b0, 64'h0};
        dir_rows[7]  = '{ROW_ITEM, 64'hff0e0d0c0b0a0908, 3'd7, 1'b1, 1'b1,
                         64'ha129ca6149be45e5};
        dir_rows[8]  = '{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 3'd0, 1'b0, 1'b0, 64'h0};
        // key change inside an open message: applies to the next one only
        dir_rows[9]  = '{ROW_KEYS, 64'hffff_ffff_ffff_ffff, 3'd0, 1'b0, 1'b0,
                         64'hffff_ffff_ffff_ffff};
        dir_rows[10] = '{ROW_ITEM, 64'h0123456789abcdef, 3'd4, 1'b1, 1'b0, 64'h0};
        dir_rows[11] = '{ROW_ITEM, 64'h0, 3'd0, 1'b1, 1'b0, 64'h0};
        dir_rows[12] = '{ROW_ITEM, 64'h8000_0000_0000_0001, 3'd5, 1'b0, 1'b0, 64'h0};
        dir_rows[13] = '{ROW_ITEM, 64'hfedcba9876543210, 3'd6, 1'b1, 1'b0, 64'h0};
        dir_rows[14] = '{ROW_KEYS, 64'h0, 3'd0, 1'b0, 1'b0, 64'h0};
        dir_rows[15] = '{ROW_ITEM, 64'hffff_ffff_ffff_ffff, 3'd2, 1'b1, 1'b0, 64'h0};

        clk             = 1'b0;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        msg_word        = '0;
        tail_bytes      = '0;
        last            = 1'b0;
        item_known      = 1'b0;
        item_known_hash = '0;
        out_ready       = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIR_ROWS; r++)
        begin
            row = dir_rows[r];
            if (row.kind == ROW_KEYS)
            begin
                drain_engine();
                write_keys(row.word, row.value);
            end
            else
                send_item(row.word, row.tail, row.last, row.known, row.value);
        end

        // Random part: one key setting per phase, extremes first.
        // Idle bursts are off in the closing phases.
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_engine();
            gaps_on   = (p < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            stalls_on = (p < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            case (p)
                0:       write_keys(64'h0, 64'h0);
                1:       write_keys(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
                2:       write_keys({$urandom, $urandom}, 64'h0);
                3:       write_keys(64'h0, 64'hffff_ffff_ffff_ffff);
                default: write_keys({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            sent      = 0;
            first_msg = 1'b1;
            while (sent < ITEMS_PER_PHASE)
            begin
                // one long message per phase pushes the length byte past 255
                if (first_msg)
                    n_words = $urandom_range(32, 34);
                else if ($urandom_range(0, 19) == 0)
                    n_words = $urandom_range(4, 12);
                else
                    n_words = $urandom_range(0, 3);
                first_msg = 1'b0;
                send_message(n_words);
                sent += n_words + 1;
                // occasionally hold off until every hash is back
                if ($urandom_range(0, 49) == 0)
                    drain_engine();
            end
        end

        drain_engine();
        if (mismatches == 0 && hash_queue.size() == 0)
            $display("keyed_sip_hash_2_4: match");
        else
            $display("keyed_sip_hash_2_4: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ksh_pkg.sv
sv/ksh_round.sv
sv/keyed_sip_hash_2_4.sv
tb/sv/testbench.sv
